// ===== rtl/core/srt_pkg.sv =====
package srt_pkg;

	// Default sizing
	localparam int CAPACITY_DEF  = 64;
	localparam int KEY_WIDTH_DEF = 32;

	// Request commands
	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_READ   = 2'd2
	} cmd_e_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DELETED   = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_READ_OK   = 3'd4,
		ST_RANGE     = 3'd5
	} status_e_t;

	// Control sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CHK,
		S_DEL_RD,
		S_DEL_CHK,
		S_DEL_SH,
		S_DEL_MV,
		S_RD_OUT
	} state_e_t;

	// One request
	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] rec_key;
		logic signed [31:0] rec_score;
		logic [5:0]         read_index;
	} req_t;

	// One result
	typedef struct packed {
		status_e_t          status;
		logic [6:0]         entry_count;
		logic [5:0]         position;
		logic signed [31:0] out_key;
		logic signed [31:0] out_score;
	} rsp_t;

endpackage

// ===== rtl/core/srt_ram.sv =====
module srt_ram #(
	parameter int DEPTH  = 64,
	parameter int DATA_W = 64,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/core/sorted_record_table_unit.sv =====
// Sorted record table: up to CAPACITY (key, score) records held in ascending
// signed key order in a single-port-style RAM with a registered read port.
// Issue a request by raising start while busy is low; the result appears on
// rsp for exactly one cycle with done high and cannot be held off. Every
// entry visited takes a RAM read state, then a compare/write-back state.
// Insert scans down from the top, moving each larger-or-equal entry up one
// slot; a full table answers straight from idle with ST_FULL. Delete scans
// up to the match and then moves the tail down. Read fetches the slot, or
// answers straight from idle when the index is out of range. A new request
// may start in the cycle the previous result is shown. No clearing pass is
// needed after reset.
module sorted_record_table_unit #(
	parameter int CAPACITY  = srt_pkg::CAPACITY_DEF,
	parameter int KEY_WIDTH = srt_pkg::KEY_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  srt_pkg::req_t req,
	output logic          done,
	output srt_pkg::rsp_t rsp
);

	import srt_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CW > 6) ? CW : 6;
	localparam int DW = KEY_WIDTH + 32;

	state_e_t          state_q, state_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [CW-1:0]     idx_q, idx_d;
	logic [AW-1:0]     pos_q, pos_d;
	req_t              req_q, req_d;
	rsp_t              rsp_q, rsp_d;
	logic              done_q, done_d;

	logic              wr_en, rd_en;
	logic [AW-1:0]     wr_addr, rd_addr;
	logic [DW-1:0]     wr_data, rd_data;

	logic [KEY_WIDTH+31:0] key_ext;
	logic [KEY_WIDTH-1:0]  new_key;
	logic [KEY_WIDTH-1:0]  rd_key;
	logic [KEY_WIDTH+31:0] rd_key_ext;
	logic [DW-1:0]         new_entry;
	logic [CW-1:0]         idx_m1, idx_p1, cnt_inc, cnt_dec;
	logic [IW+5:0]         ridx_ext, cnt_ext;
	logic                  ridx_range;

	// Output field resizing
	function automatic logic [6:0] to_cnt7(input logic [CW-1:0] v);
		logic [CW+6:0] t;
		t = {7'd0, v};
		return t[6:0];
	endfunction

	function automatic logic [5:0] to_pos6(input logic [AW-1:0] v);
		logic [AW+5:0] t;
		t = {6'd0, v};
		return t[5:0];
	endfunction

	// Key taken from the low bits of the request key
	assign key_ext    = {{KEY_WIDTH{1'b0}}, req_q.rec_key};
	assign new_key    = key_ext[KEY_WIDTH-1:0];
	assign new_entry  = {new_key, req_q.rec_score};
	assign rd_key     = rd_data[DW-1:32];
	assign rd_key_ext = {32'd0, rd_key};

	assign idx_m1  = idx_q - 1'b1;
	assign idx_p1  = idx_q + 1'b1;
	assign cnt_inc = cnt_q + 1'b1;
	assign cnt_dec = cnt_q - 1'b1;

	// Read index range check against the live count
	assign ridx_ext   = {{IW{1'b0}}, req.read_index};
	assign cnt_ext    = {{(IW+6-CW){1'b0}}, cnt_q};
	assign ridx_range = ridx_ext[IW-1:0] >= cnt_ext[IW-1:0];

	srt_ram #(
		.DEPTH  (CAPACITY),
		.DATA_W (DW),
		.ADDR_W (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Sequencer: next state, datapath updates and RAM controls
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		idx_d   = idx_q;
		pos_d   = pos_q;
		req_d   = req_q;
		rsp_d   = rsp_q;
		done_d  = 1'b0;
		rd_en   = 1'b0;
		rd_addr = idx_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_data = new_entry;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					req_d = req;
					case (req.command)
						CMD_INSERT: begin
							if (cnt_q == CW'(CAPACITY)) begin
								rsp_d = '{ST_FULL, to_cnt7(cnt_q), 6'd0, 32'sd0, 32'sd0};
								done_d = 1'b1;
							end else begin
								idx_d   = cnt_q;
								state_d = S_INS_RD;
							end
						end
						CMD_DELETE: begin
							idx_d   = '0;
							state_d = S_DEL_RD;
						end
						CMD_READ: begin
							if (ridx_range) begin
								rsp_d = '{ST_RANGE, to_cnt7(cnt_q), req.read_index,
									32'sd0, 32'sd0};
								done_d = 1'b1;
							end else begin
								rd_en   = 1'b1;
								rd_addr = ridx_ext[AW-1:0];
								state_d = S_RD_OUT;
							end
						end
						default: begin
						end
					endcase
				end
			end

			// Insert: idx_q is the free slot, entry below it is compared
			S_INS_RD: begin
				if (idx_q == '0) begin
					wr_en   = 1'b1;
					cnt_d   = cnt_inc;
					rsp_d   = '{ST_INSERTED, to_cnt7(cnt_inc), 6'd0, 32'sd0, 32'sd0};
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = idx_m1[AW-1:0];
					state_d = S_INS_CHK;
				end
			end

			S_INS_CHK: begin
				wr_en = 1'b1;
				if ($signed(rd_key) >= $signed(new_key)) begin
					wr_data = rd_data;
					idx_d   = idx_m1;
					state_d = S_INS_RD;
				end else begin
					cnt_d   = cnt_inc;
					rsp_d   = '{ST_INSERTED, to_cnt7(cnt_inc), to_pos6(idx_q[AW-1:0]),
						32'sd0, 32'sd0};
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end

			// Delete: forward search for the first equal key
			S_DEL_RD: begin
				if (idx_q == cnt_q) begin
					rsp_d   = '{ST_NOT_FOUND, to_cnt7(cnt_q), 6'd0, 32'sd0, 32'sd0};
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					state_d = S_DEL_CHK;
				end
			end

			S_DEL_CHK: begin
				if ($signed(rd_key) < $signed(new_key)) begin
					idx_d   = idx_p1;
					state_d = S_DEL_RD;
				end else if (rd_key == new_key) begin
					pos_d   = idx_q[AW-1:0];
					idx_d   = idx_p1;
					state_d = S_DEL_SH;
				end else begin
					rsp_d   = '{ST_NOT_FOUND, to_cnt7(cnt_q), 6'd0, 32'sd0, 32'sd0};
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end

			// Delete: move the tail down one slot
			S_DEL_SH: begin
				if (idx_q == cnt_q) begin
					cnt_d   = cnt_dec;
					rsp_d   = '{ST_DELETED, to_cnt7(cnt_dec), to_pos6(pos_q),
						32'sd0, 32'sd0};
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					state_d = S_DEL_MV;
				end
			end

			S_DEL_MV: begin
				wr_en   = 1'b1;
				wr_addr = idx_m1[AW-1:0];
				wr_data = rd_data;
				idx_d   = idx_p1;
				state_d = S_DEL_SH;
			end

			S_RD_OUT: begin
				rsp_d   = '{ST_READ_OK, to_cnt7(cnt_q), req_q.read_index,
					rd_key_ext[31:0], rd_data[31:0]};
				done_d  = 1'b1;
				state_d = S_IDLE;
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			cnt_q  <= cnt_d;
			done_q <= done_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		pos_q <= pos_d;
		req_q <= req_d;
		rsp_q <= rsp_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== verif/tb_sorted_record_table_unit.sv =====
module tb_sorted_record_table_unit;
	import srt_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 300;
	// Command code that the unit accepts and then ignores
	localparam logic [1:0] CMD_IGNORED = 2'd3;
	localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	logic  busy;
	logic  done;
	req_t  req_bus = '0;
	rsp_t  rsp_bus;

	// Shadow copy of the table, updated as each request is accepted
	logic signed [31:0] shadow_key [TABLE_DEPTH];
	logic signed [31:0] shadow_score [TABLE_DEPTH];
	int                 shadow_count = 0;

	rsp_t pending_rsp [$];
	int   fail_count = 0;
	int   cycle_count = 0;
	int   idle_pct = 0;

	sorted_record_table_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req_bus),
		.done   (done),
		.rsp    (rsp_bus)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// First slot whose key is not below k
	function automatic int first_not_below(logic signed [31:0] k);
		int i;
		i = 0;
		while (i < shadow_count && shadow_key[i] < k)
			i++;
		return i;
	endfunction

	// Apply one request to the shadow table and form the expected result
	function automatic bit table_outcome(input req_t r, output rsp_t o);
		int p;
		int i;
		o = '0;
		case (r.command)
			CMD_INSERT: begin
				if (shadow_count >= TABLE_DEPTH) begin
					o.status = ST_FULL;
				end else begin
					p = first_not_below(r.rec_key);
					for (i = shadow_count; i > p; i--) begin
						shadow_key[i] = shadow_key[i - 1];
						shadow_score[i] = shadow_score[i - 1];
					end
					shadow_key[p] = r.rec_key;
					shadow_score[p] = r.rec_score;
					shadow_count++;
					o.status = ST_INSERTED;
					o.position = p[5:0];
				end
			end
			CMD_DELETE: begin
				p = first_not_below(r.rec_key);
				if (p >= shadow_count || shadow_key[p] != r.rec_key) begin
					o.status = ST_NOT_FOUND;
				end else begin
					for (i = p; i + 1 < shadow_count; i++) begin
						shadow_key[i] = shadow_key[i + 1];
						shadow_score[i] = shadow_score[i + 1];
					end
					shadow_count--;
					o.status = ST_DELETED;
					o.position = p[5:0];
				end
			end
			CMD_READ: begin
				o.position = r.read_index;
				if (int'(r.read_index) >= shadow_count) begin
					o.status = ST_RANGE;
				end else begin
					o.status = ST_READ_OK;
					o.out_key = shadow_key[r.read_index];
					o.out_score = shadow_score[r.read_index];
				end
			end
			default: return 1'b0;
		endcase
		o.entry_count = shadow_count[6:0];
		return 1'b1;
	endfunction

	// Issue one request, wait for it to be taken, then maybe idle a while
	task automatic issue(input logic [1:0] cmd, input logic signed [31:0] k,
			input logic signed [31:0] s, input logic [5:0] idx);
		req_t r;
		rsp_t o;
		int   gap;
		r.command = cmd;
		r.rec_key = k;
		r.rec_score = s;
		r.read_index = idx;
		start <= 1'b1;
		req_bus <= r;
		do @(posedge clk); while (busy !== 1'b0);
		if (table_outcome(r, o))
			pending_rsp.push_back(o);
		if (int'($urandom_range(0, 99)) < idle_pct) begin
			start <= 1'b0;
			gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 50);
			repeat (gap) @(posedge clk);
		end
	endtask

	// Keys: small pool for collisions, extremes, held keys, or anything
	function automatic logic signed [31:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return $signed(32'($urandom_range(0, 11)) - 32'd4);
		if (r < 40)
			return ($urandom_range(0, 1)) ? KEY_MIN : KEY_MAX;
		if (r < 65 && shadow_count > 0)
			return shadow_key[$urandom_range(0, shadow_count - 1)];
		return $signed($urandom());
	endfunction

	// Result checker: every strobe must match the oldest expectation
	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_rsp.size() == 0) begin
				$error("result with nothing expected: %p", rsp_bus);
				fail_count++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp_bus.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_bus.status);
					fail_count++;
				end
				if (rsp_bus.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d",
						want.entry_count, rsp_bus.entry_count);
					fail_count++;
				end
				if (rsp_bus.position !== want.position) begin
					$error("position: expected %0d, got %0d", want.position, rsp_bus.position);
					fail_count++;
				end
				if (rsp_bus.out_key !== want.out_key) begin
					$error("out_key: expected %0d, got %0d", want.out_key, rsp_bus.out_key);
					fail_count++;
				end
				if (rsp_bus.out_score !== want.out_score) begin
					$error("out_score: expected %0d, got %0d", want.out_score, rsp_bus.out_score);
					fail_count++;
				end
			end
		end
	end

	// Empty table, extremes, duplicate keys, ignored command
	task automatic test_directed();
		int i;
		idle_pct = 0;
		issue(CMD_READ, 0, 0, 6'd0);
		issue(CMD_READ, 0, 0, 6'd63);
		issue(CMD_DELETE, 0, 0, 6'd0);
		issue(CMD_INSERT, 0, 0, 6'd0);
		issue(CMD_INSERT, KEY_MAX, KEY_MAX, 6'd0);
		issue(CMD_INSERT, KEY_MIN, KEY_MIN, 6'd63);
		issue(CMD_INSERT, -1, -1, 6'd0);
		// equal key lands in front of the existing one
		issue(CMD_INSERT, 0, 1234, 6'd0);
		issue(CMD_INSERT, 1, 32'sh5555_5555, 6'd0);
		issue(CMD_INSERT, KEY_MAX, 32'shaaaa_aaaa, 6'd0);
		issue(CMD_IGNORED, -1, -1, 6'd63);
		idle_pct = 40;
		for (i = 0; i < 8; i++)
			issue(CMD_READ, 0, 0, i[5:0]);
		issue(CMD_DELETE, 0, 0, 6'd0);
		issue(CMD_DELETE, KEY_MIN, 0, 6'd0);
		issue(CMD_DELETE, 12345, 0, 6'd0);
		issue(CMD_READ, 0, 0, 6'd0);
		issue(CMD_READ, 0, 0, 6'd3);
	endtask

	// Fill to capacity, bounce off the full table, read the top slot
	task automatic test_full_table();
		int i;
		idle_pct = 20;
		while (shadow_count < TABLE_DEPTH)
			issue(CMD_INSERT, pick_key(), $signed($urandom()), 6'($urandom()));
		for (i = 0; i < 4; i++)
			issue(CMD_INSERT, pick_key(), $signed($urandom()), 6'($urandom()));
		issue(CMD_READ, 0, 0, 6'd63);
		issue(CMD_READ, 0, 0, 6'd0);
		issue(CMD_DELETE, shadow_key[63], 0, 6'd0);
		issue(CMD_READ, 0, 0, 6'd63);
		issue(CMD_INSERT, KEY_MAX, -5, 6'd0);
		issue(CMD_INSERT, KEY_MIN, 5, 6'd0);
		issue(CMD_READ, 0, 0, 6'd63);
	endtask

	// Mixed traffic, biased to keep the table away from both ends
	task automatic test_random_mix(input int n);
		int i;
		int r;
		int ins_w;
		logic [5:0] idx;
		for (i = 0; i < n; i++) begin
			if (i % 60 == 0)
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 30;
					default: idle_pct = 70;
				endcase
			ins_w = (shadow_count < 8) ? 65 : (shadow_count > 56) ? 25 : 40;
			r = $urandom_range(0, 99);
			if (r < ins_w) begin
				issue(CMD_INSERT, pick_key(), $signed($urandom()), 6'($urandom()));
			end else if (r < ins_w + 30) begin
				issue(CMD_DELETE, pick_key(), $signed($urandom()), 6'($urandom()));
			end else if (r < 97) begin
				if (shadow_count > 0 && $urandom_range(0, 9) < 7)
					idx = 6'($urandom_range(0, shadow_count - 1));
				else
					idx = 6'($urandom());
				issue(CMD_READ, $signed($urandom()), $signed($urandom()), idx);
			end else begin
				issue(CMD_IGNORED, $signed($urandom()), $signed($urandom()), 6'($urandom()));
			end
		end
	endtask

	// Remove every held record in random order, then probe the empty table
	task automatic test_drain();
		idle_pct = 25;
		while (shadow_count > 0)
			issue(CMD_DELETE, shadow_key[$urandom_range(0, shadow_count - 1)],
				$signed($urandom()), 6'($urandom()));
		issue(CMD_DELETE, KEY_MAX, 0, 6'd0);
		issue(CMD_READ, 0, 0, 6'd0);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_table();
		test_random_mix(480);
		test_drain();
		start <= 1'b0;
		while (pending_rsp.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/srt_pkg.sv
rtl/core/srt_ram.sv
rtl/core/sorted_record_table_unit.sv
verif/tb_sorted_record_table_unit.sv
